/* rtl/core/sbox_pkg.sv */
// Shared widths, register indexes and configuration types for the sub-box offset generator.
package sbox_pkg;

   localparam int unsigned OFFSET_W       = 30;
   localparam int unsigned EXT_W          = 11;
   localparam int unsigned ORG_W          = 10;
   localparam int unsigned CSR_IDX_W      = 4;
   localparam int unsigned CSR_DATA_W     = 11;
   localparam int unsigned ZH_W           = 22;
   localparam int unsigned STRIDE_W       = 22;
   localparam int unsigned START_PROD_W   = ZH_W + EXT_W;
   localparam int unsigned SETTLE_W       = 2;
   localparam int unsigned SETTLE_CYCLES  = 2;
   localparam int unsigned MAX_EXTENT_DEF = 1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_ROW_LENGTH    = 4'd0,
      REG_GRID_COLUMN_HEIGHT = 4'd1,
      REG_BOX_ORIGIN_X       = 4'd2,
      REG_BOX_ORIGIN_Y       = 4'd3,
      REG_BOX_ORIGIN_Z       = 4'd4,
      REG_BOX_EXTENT_X       = 4'd5,
      REG_BOX_EXTENT_Y       = 4'd6,
      REG_BOX_EXTENT_Z       = 4'd7
   } csr_reg_type;

   typedef struct packed {
      logic [EXT_W-1:0]    row_length;
      logic [EXT_W-1:0]    extent_x;
      logic [EXT_W-1:0]    extent_y;
      logic [EXT_W-1:0]    extent_z;
      logic [OFFSET_W-1:0] start_offset;
      logic [STRIDE_W-1:0] plane_stride;
   } walk_cfg_type;

endpackage

/* rtl/core/sbox_cfg.sv */
// Configuration registers with registered start offset and plane stride products.
module sbox_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sbox_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbox_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output sbox_pkg::walk_cfg_type           walk_cfg,
   output logic                             busy
);
   import sbox_pkg::*;

   logic [EXT_W-1:0]        grid_row_length_ff;
   logic [EXT_W-1:0]        grid_column_height_ff;
   logic [ORG_W-1:0]        box_origin_x_ff;
   logic [ORG_W-1:0]        box_origin_y_ff;
   logic [ORG_W-1:0]        box_origin_z_ff;
   logic [EXT_W-1:0]        box_extent_x_ff;
   logic [EXT_W-1:0]        box_extent_y_ff;
   logic [EXT_W-1:0]        box_extent_z_ff;
   logic [ZH_W-1:0]         zh_ff;
   logic [ZH_W-1:0]         zh_in;
   logic [STRIDE_W-1:0]     stride_ff;
   logic [STRIDE_W-1:0]     stride_in;
   logic [OFFSET_W-1:0]     start_ff;
   logic [OFFSET_W-1:0]     start_in;
   logic [START_PROD_W-1:0] start_prod;
   logic [SETTLE_W-1:0]     settle_ff;
   logic [SETTLE_W-1:0]     settle_in;
   logic                    write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_row_length_ff    <= EXT_W'(1);
         grid_column_height_ff <= EXT_W'(1);
         box_origin_x_ff       <= '0;
         box_origin_y_ff       <= '0;
         box_origin_z_ff       <= '0;
         box_extent_x_ff       <= EXT_W'(1);
         box_extent_y_ff       <= EXT_W'(1);
         box_extent_z_ff       <= EXT_W'(1);
      end else if (write_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_GRID_ROW_LENGTH:    grid_row_length_ff    <= csr_wdata;
            REG_GRID_COLUMN_HEIGHT: grid_column_height_ff <= csr_wdata;
            REG_BOX_ORIGIN_X:       box_origin_x_ff       <= csr_wdata[ORG_W-1:0];
            REG_BOX_ORIGIN_Y:       box_origin_y_ff       <= csr_wdata[ORG_W-1:0];
            REG_BOX_ORIGIN_Z:       box_origin_z_ff       <= csr_wdata[ORG_W-1:0];
            REG_BOX_EXTENT_X:       box_extent_x_ff       <= csr_wdata;
            REG_BOX_EXTENT_Y:       box_extent_y_ff       <= csr_wdata;
            REG_BOX_EXTENT_Z:       box_extent_z_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // plane row index of the box origin, then its element offset
   assign zh_in      = ZH_W'(box_origin_z_ff) * ZH_W'(grid_column_height_ff)
                       + ZH_W'(box_origin_y_ff);
   assign stride_in  = STRIDE_W'(grid_row_length_ff) * STRIDE_W'(grid_column_height_ff);
   assign start_prod = START_PROD_W'(zh_ff) * START_PROD_W'(grid_row_length_ff);
   assign start_in   = start_prod[OFFSET_W-1:0] + OFFSET_W'(box_origin_x_ff);

   always_comb begin
      if (write_en) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zh_ff     <= '0;
         stride_ff <= STRIDE_W'(1);
         start_ff  <= '0;
         settle_ff <= '0;
      end else begin
         zh_ff     <= zh_in;
         stride_ff <= stride_in;
         start_ff  <= start_in;
         settle_ff <= settle_in;
      end
   end

   assign busy                  = settle_ff != '0;
   assign walk_cfg.row_length   = grid_row_length_ff;
   assign walk_cfg.extent_x     = box_extent_x_ff;
   assign walk_cfg.extent_y     = box_extent_y_ff;
   assign walk_cfg.extent_z     = box_extent_z_ff;
   assign walk_cfg.start_offset = start_ff;
   assign walk_cfg.plane_stride = stride_ff;

endmodule

/* rtl/core/subbox_offset_generator.sv */
// Top level of the sub-box offset generator: walk counters, bases and result register.
//
// Walks a sub-box inside a row-major 3D grid and returns one grid offset per request item,
// x fastest, then y, then z, with row, plane and box end marks; after the last element the
// walk wraps to the first offset, and a request with restart set (or the first one after
// reset) begins at the first offset. An item is accepted every clock while req_stall is low,
// and its result is in the result register in the cycle after; the next offset needs only an
// increment or one 30-bit add of the row length or plane stride. The start offset and plane
// stride are products kept in registers that follow the configuration, so after each
// configuration write the request side is stalled while they settle. Extents of zero act
// as one and extents above MAX_EXTENT are clipped to it; nothing checks that the box lies
// inside the grid, and offsets wrap modulo 2^30.
module subbox_offset_generator #(
   parameter int unsigned MAX_EXTENT = sbox_pkg::MAX_EXTENT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sbox_pkg::OFFSET_W-1:0]   rsp_linear_offset,
   output logic                            rsp_row_end,
   output logic                            rsp_plane_end,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sbox_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbox_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sbox_pkg::*;

   localparam int unsigned CNT_W = (MAX_EXTENT > 2) ? $clog2(MAX_EXTENT) : 1;
   localparam int unsigned CMP_W = ((CNT_W > EXT_W) ? CNT_W : EXT_W) + 1;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_EXTENT);

   walk_cfg_type        walk_cfg;
   logic                cfg_busy;
   logic                accept;
   logic                load;

   logic [CNT_W-1:0]    x_count_ff, x_count_in;
   logic [CNT_W-1:0]    y_count_ff, y_count_in;
   logic [CNT_W-1:0]    z_count_ff, z_count_in;
   logic [OFFSET_W-1:0] row_base_ff, row_base_in;
   logic [OFFSET_W-1:0] plane_base_ff, plane_base_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                started_ff;

   logic [CNT_W-1:0]    cx, cy, cz;
   logic [OFFSET_W-1:0] cur, rb, pb;
   logic                xe, ye, ze;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic                rsp_row_end_ff;
   logic                rsp_plane_end_ff;
   logic                rsp_last_ff;

   function automatic logic [CMP_W-1:0] eff_extent(input logic [EXT_W-1:0] e);
      logic [CMP_W-1:0] w;
      w = CMP_W'(e);
      if (w == '0) begin
         return CMP_W'(1);
      end else if (w > MAX_CMP) begin
         return MAX_CMP;
      end
      return w;
   endfunction

   sbox_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .walk_cfg  (walk_cfg),
      .busy      (cfg_busy)
   );

   assign req_stall = cfg_busy || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign load      = req_restart || !started_ff;

   always_comb begin
      cx  = load ? '0 : x_count_ff;
      cy  = load ? '0 : y_count_ff;
      cz  = load ? '0 : z_count_ff;
      cur = load ? walk_cfg.start_offset : offset_ff;
      rb  = load ? walk_cfg.start_offset : row_base_ff;
      pb  = load ? walk_cfg.start_offset : plane_base_ff;

      xe = (CMP_W'(cx) + CMP_W'(1)) >= eff_extent(walk_cfg.extent_x);
      ye = (CMP_W'(cy) + CMP_W'(1)) >= eff_extent(walk_cfg.extent_y);
      ze = (CMP_W'(cz) + CMP_W'(1)) >= eff_extent(walk_cfg.extent_z);

      x_count_in    = cx;
      y_count_in    = cy;
      z_count_in    = cz;
      row_base_in   = rb;
      plane_base_in = pb;
      offset_in     = cur;
      if (!xe) begin
         x_count_in = cx + CNT_W'(1);
         offset_in  = cur + OFFSET_W'(1);
      end else if (!ye) begin
         x_count_in  = '0;
         y_count_in  = cy + CNT_W'(1);
         row_base_in = rb + OFFSET_W'(walk_cfg.row_length);
         offset_in   = rb + OFFSET_W'(walk_cfg.row_length);
      end else if (!ze) begin
         x_count_in    = '0;
         y_count_in    = '0;
         z_count_in    = cz + CNT_W'(1);
         plane_base_in = pb + OFFSET_W'(walk_cfg.plane_stride);
         row_base_in   = pb + OFFSET_W'(walk_cfg.plane_stride);
         offset_in     = pb + OFFSET_W'(walk_cfg.plane_stride);
      end else begin
         x_count_in    = '0;
         y_count_in    = '0;
         z_count_in    = '0;
         row_base_in   = walk_cfg.start_offset;
         plane_base_in = walk_cfg.start_offset;
         offset_in     = walk_cfg.start_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff    <= '0;
         y_count_ff    <= '0;
         z_count_ff    <= '0;
         row_base_ff   <= '0;
         plane_base_ff <= '0;
         offset_ff     <= '0;
         started_ff    <= 1'b0;
      end else if (accept) begin
         x_count_ff    <= x_count_in;
         y_count_ff    <= y_count_in;
         z_count_ff    <= z_count_in;
         row_base_ff   <= row_base_in;
         plane_base_ff <= plane_base_in;
         offset_ff     <= offset_in;
         started_ff    <= 1'b1;
      end
   end

   // hold the result while stalled, drop it once taken
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_offset_ff    <= cur;
         rsp_row_end_ff   <= xe;
         rsp_plane_end_ff <= xe && ye;
         rsp_last_ff      <= xe && ye && ze;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_linear_offset = rsp_offset_ff;
   assign rsp_row_end       = rsp_row_end_ff;
   assign rsp_plane_end     = rsp_plane_end_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* rtl/core/sbox_checker.sv */
// Port-level checker for the sub-box offset generator and its bind.
module sbox_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [sbox_pkg::OFFSET_W-1:0]   rsp_linear_offset,
   input logic                            rsp_row_end,
   input logic                            rsp_plane_end,
   input logic                            rsp_last,
   input logic                            csr_valid,
   input logic                            csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_linear_offset))
      else $error("stalled result changed");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_plane_end && rsp_row_end)
      else $error("box end without plane and row end");

   a_plane_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_plane_end |-> rsp_row_end)
      else $error("plane end without row end");

   a_item_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   a_cfg_settle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("request taken while configuration settles");

endmodule

bind subbox_offset_generator sbox_checker u_sbox_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_linear_offset (rsp_linear_offset),
   .rsp_row_end       (rsp_row_end),
   .rsp_plane_end     (rsp_plane_end),
   .rsp_last          (rsp_last),
   .csr_valid         (csr_valid),
   .csr_ready         (csr_ready)
);
